// File: rtl/afc_pkg.sv
// afc_pkg: shared types and constants for the box versus frustum culling block
// payload structs, plane codes and matrix reset values; no dependencies
`timescale 1ns / 1ps

package afc_pkg;

    localparam int COORD_BITS     = 24;
    localparam int COEF_BITS_DEF  = 16;
    localparam int NUM_ROWS       = 4;
    localparam int NUM_PLANES     = 6;
    localparam int NUM_AXES       = 3;
    localparam int NUM_COLS       = 4;
    localparam int COL_BITS       = 16;
    localparam int ROW_BITS       = 64;
    localparam int FRAC_BITS      = 8;
    localparam int CFG_INDEX_BITS = 2;

    // plane codes, in test order
    typedef enum logic [2:0] {
        PLANE_LEFT   = 3'd0,
        PLANE_RIGHT  = 3'd1,
        PLANE_BOTTOM = 3'd2,
        PLANE_TOP    = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5,
        PLANE_NONE   = 3'd6
    } plane_id_t;

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MATRIX_ROW0 = 2'd0,
        REG_MATRIX_ROW1 = 2'd1,
        REG_MATRIX_ROW2 = 2'd2,
        REG_MATRIX_ROW3 = 2'd3
    } cfg_reg_t;

    // identity matrix in Q8.8
    localparam logic [ROW_BITS-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_BITS-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_BITS-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_BITS-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } box_t;

    typedef struct packed {
        logic      visible;
        plane_id_t rejecting_plane;
    } result_t;

    // per-stage load enables handed to the plane evaluators
    typedef struct packed {
        logic prod_ld;
        logic sum_ld;
    } stage_ld_t;

endpackage

// File: rtl/aabb_frustum_cull.sv
// aabb_frustum_cull: top level of the box versus view-frustum culling pipeline
// depends on afc_pkg, afc_planes, afc_plane_eval
`timescale 1ns / 1ps

// Takes one box request per clock unless box_stall is raised and returns one
// result per box, in order. An accepted box passes through the input
// register, product stage (eighteen parallel multipliers, three per plane),
// sum stage, then the first-rejecting-plane encoder into the output
// register. Every stage holds under stall and bubbles close up, so a waiting
// result holds back new boxes only once all four stages are full. Matrix
// writes reach the plane coefficient register in the cycle after the write.

module aabb_frustum_cull #(
    parameter int COEF_BITS = afc_pkg::COEF_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [afc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [afc_pkg::ROW_BITS-1:0]        cfg_data,
    input  logic                                box_valid,
    output logic                                box_stall,
    input  afc_pkg::box_t                       box,
    output logic                                result_valid,
    input  logic                                result_stall,
    output afc_pkg::result_t                    result
);
    import afc_pkg::*;

    logic [NUM_PLANES-1:0][NUM_COLS-1:0][COEF_BITS:0] plane_coef;
    logic [NUM_PLANES-1:0] outside;

    logic    in_v_reg, prod_v_reg, sum_v_reg, out_v_reg;
    logic    in_rdy, prod_rdy, sum_rdy, out_rdy;
    box_t    box_reg;
    result_t result_reg;
    result_t result_next;
    stage_ld_t ld;

    afc_planes #(
        .COEF_BITS (COEF_BITS)
    ) u_planes (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .plane_coef (plane_coef)
    );

    // a stage takes new data when empty or when the stage after it moves
    assign out_rdy  = !out_v_reg || !result_stall;
    assign sum_rdy  = !sum_v_reg || out_rdy;
    assign prod_rdy = !prod_v_reg || sum_rdy;
    assign in_rdy   = !in_v_reg || prod_rdy;

    assign ld.prod_ld = prod_rdy;
    assign ld.sum_ld  = sum_rdy;

    assign box_stall = !in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (in_rdy)
                in_v_reg <= box_valid;
            if (prod_rdy)
                prod_v_reg <= in_v_reg;
            if (sum_rdy)
                sum_v_reg <= prod_v_reg;
            if (out_rdy)
                out_v_reg <= sum_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy)
            box_reg <= box;
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        afc_plane_eval #(
            .COEF_BITS (COEF_BITS)
        ) u_eval (
            .clk     (clk),
            .ld      (ld),
            .box     (box_reg),
            .coef    (plane_coef[p]),
            .outside (outside[p])
        );
    end

    // lowest-numbered rejecting plane wins
    always_comb
    begin
        result_next.visible         = 1'b1;
        result_next.rejecting_plane = PLANE_NONE;
        for (int p = NUM_PLANES - 1; p >= 0; p--)
        begin
            if (outside[p])
            begin
                result_next.visible         = 1'b0;
                result_next.rejecting_plane = plane_id_t'(3'(p));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
            result_reg <= result_next;
    end

    assign result_valid = out_v_reg;
    assign result       = result_reg;

endmodule

// File: rtl/afc_planes.sv
// afc_planes: matrix row registers and derived frustum plane coefficients
// depends on afc_pkg
`timescale 1ns / 1ps

module afc_planes #(
    parameter int COEF_BITS = afc_pkg::COEF_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [afc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [afc_pkg::ROW_BITS-1:0]          cfg_data,
    output logic [afc_pkg::NUM_PLANES-1:0][afc_pkg::NUM_COLS-1:0][COEF_BITS:0] plane_coef
);
    import afc_pkg::*;

    logic [ROW_BITS-1:0] matrix_reg [NUM_ROWS];
    logic [NUM_PLANES-1:0][NUM_COLS-1:0][COEF_BITS:0] plane_reg;
    logic [NUM_PLANES-1:0][NUM_COLS-1:0][COEF_BITS:0] plane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg[0] <= ROW0_RESET;
            matrix_reg[1] <= ROW1_RESET;
            matrix_reg[2] <= ROW2_RESET;
            matrix_reg[3] <= ROW3_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MATRIX_ROW0: matrix_reg[0] <= cfg_data;
                REG_MATRIX_ROW1: matrix_reg[1] <= cfg_data;
                REG_MATRIX_ROW2: matrix_reg[2] <= cfg_data;
                REG_MATRIX_ROW3: matrix_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // plane p uses row p/2; odd planes subtract it from row 3
    always_comb
    begin
        logic signed [COEF_BITS:0] r3;
        logic signed [COEF_BITS:0] rk;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int k = 0; k < NUM_COLS; k++)
            begin
                r3 = (COEF_BITS+1)'(signed'(matrix_reg[3][COL_BITS*k +: COEF_BITS]));
                rk = (COEF_BITS+1)'(signed'(matrix_reg[p/2][COL_BITS*k +: COEF_BITS]));
                plane_next[p][k] = (p % 2 == 1) ? r3 - rk : r3 + rk;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg <= plane_next;
    end

    assign plane_coef = plane_reg;

endmodule

// File: rtl/afc_plane_eval.sv
// afc_plane_eval: positive-vertex products and signed sum for one plane
// two register stages; depends on afc_pkg
`timescale 1ns / 1ps

module afc_plane_eval #(
    parameter int COEF_BITS = afc_pkg::COEF_BITS_DEF
) (
    input  logic                                       clk,
    input  afc_pkg::stage_ld_t                         ld,
    input  afc_pkg::box_t                              box,
    input  logic [afc_pkg::NUM_COLS-1:0][COEF_BITS:0]  coef,
    output logic                                       outside
);
    import afc_pkg::*;

    localparam int PROD_BITS = COEF_BITS + 1 + COORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    logic signed [COORD_BITS-1:0] lo [NUM_AXES];
    logic signed [COORD_BITS-1:0] hi [NUM_AXES];
    logic signed [PROD_BITS-1:0]  prod_next [NUM_AXES];
    logic signed [PROD_BITS-1:0]  prod_reg  [NUM_AXES];
    logic signed [SUM_BITS-1:0]   sum;
    logic signed [SUM_BITS-1:0]   w_term;
    logic                         outside_reg;

    assign lo[0] = box.min_x;
    assign lo[1] = box.min_y;
    assign lo[2] = box.min_z;
    assign hi[0] = box.max_x;
    assign hi[1] = box.max_y;
    assign hi[2] = box.max_z;

    // non-negative normal component picks the max corner
    always_comb
    begin
        logic signed [COEF_BITS:0]    c;
        logic signed [COORD_BITS-1:0] v;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            c = signed'(coef[a]);
            v = c[COEF_BITS] ? lo[a] : hi[a];
            prod_next[a] = PROD_BITS'(c) * PROD_BITS'(v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.prod_ld)
        begin
            for (int a = 0; a < NUM_AXES; a++)
                prod_reg[a] <= prod_next[a];
        end
    end

    // w scaled by one in Q8.8
    assign w_term = SUM_BITS'(signed'({coef[NUM_COLS-1], {FRAC_BITS{1'b0}}}));
    assign sum = SUM_BITS'(prod_reg[0]) + SUM_BITS'(prod_reg[1])
               + SUM_BITS'(prod_reg[2]) + w_term;

    always_ff @(posedge clk)
    begin
        if (ld.sum_ld)
            outside_reg <= sum[SUM_BITS-1];
    end

    assign outside = outside_reg;

endmodule

// File: test/aabb_frustum_cull_tb.sv
// aabb_frustum_cull_tb: self-checking bench for the box versus frustum culling block
// predicts visibility and the first rejecting plane for every box request
// depends on afc_pkg and aabb_frustum_cull
`timescale 1ns / 1ps

module aabb_frustum_cull_tb;
    import afc_pkg::*;

    localparam int COEF_W = COEF_BITS_DEF;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MATRIX_ROW0;
    logic [ROW_BITS-1:0]       cfg_data = '0;
    logic                      box_valid = 1'b0;
    logic                      box_stall;
    box_t                      box = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result;

    // local copy of the matrix registers
    logic [ROW_BITS-1:0] mat_rows [NUM_ROWS] = '{ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET};

    box_t        pending_boxes [$];
    result_t     expected_verdicts [$];
    box_t        taken_box;
    logic        box_taken = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_phase = 0;
    int          fail_count = 0;

    aabb_frustum_cull dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .box_valid    (box_valid),
        .box_stall    (box_stall),
        .box          (box),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint coef_at(int row, int col);
        logic [COL_BITS-1:0]      slot;
        logic signed [COEF_W-1:0] s;
        slot = mat_rows[row][COL_BITS*col +: COL_BITS];
        s = slot[COEF_W-1:0];
        return longint'(s);
    endfunction

    // planes are row3 +/- row(p/2); positive vertex picked per axis by normal sign
    function automatic result_t classify_box(input box_t b);
        longint    lo [NUM_AXES];
        longint    hi [NUM_AXES];
        longint    c [NUM_COLS];
        longint    acc;
        result_t   r;
        plane_id_t hit;
        hit = PLANE_NONE;
        lo[0] = longint'(signed'(b.min_x));
        lo[1] = longint'(signed'(b.min_y));
        lo[2] = longint'(signed'(b.min_z));
        hi[0] = longint'(signed'(b.max_x));
        hi[1] = longint'(signed'(b.max_y));
        hi[2] = longint'(signed'(b.max_z));
        for (int p = 0; p < NUM_PLANES && hit == PLANE_NONE; p++)
        begin
            for (int k = 0; k < NUM_COLS; k++)
            begin
                if (p % 2 == 1)
                    c[k] = coef_at(3, k) - coef_at(p / 2, k);
                else
                    c[k] = coef_at(3, k) + coef_at(p / 2, k);
            end
            acc = c[3] * (longint'(1) <<< FRAC_BITS);
            for (int a = 0; a < NUM_AXES; a++)
                acc += c[a] * ((c[a] >= 0) ? hi[a] : lo[a]);
            if (acc < 0)
                hit = plane_id_t'(3'(p));
        end
        r.visible = (hit == PLANE_NONE);
        r.rejecting_plane = hit;
        return r;
    endfunction

    function automatic box_t mk_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
        box_t b;
        b.min_x = mnx[COORD_BITS-1:0];
        b.min_y = mny[COORD_BITS-1:0];
        b.min_z = mnz[COORD_BITS-1:0];
        b.max_x = mxx[COORD_BITS-1:0];
        b.max_y = mxy[COORD_BITS-1:0];
        b.max_z = mxz[COORD_BITS-1:0];
        return b;
    endfunction

    function automatic box_t random_box();
        logic signed [COORD_BITS-1:0] lo_v [NUM_AXES];
        logic signed [COORD_BITS-1:0] hi_v [NUM_AXES];
        logic signed [COORD_BITS-1:0] t;
        int          span;
        int          mid;
        int          half;
        int unsigned flavour;
        flavour = $urandom_range(0, 7);
        span = (flavour < 3) ? 512 : (flavour < 5) ? 4096 : 65536;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (flavour == 7)
            begin
                lo_v[a] = COORD_BITS'($urandom);
                hi_v[a] = COORD_BITS'($urandom);
            end
            else
            begin
                mid = int'($urandom_range(0, 2 * span)) - span;
                half = int'($urandom_range(0, span));
                lo_v[a] = COORD_BITS'(mid - half);
                hi_v[a] = COORD_BITS'(mid + half);
            end
            // now and then the corners come the wrong way round
            if ($urandom_range(0, 9) == 0)
            begin
                t = lo_v[a];
                lo_v[a] = hi_v[a];
                hi_v[a] = t;
            end
        end
        return mk_box(int'(lo_v[0]), int'(lo_v[1]), int'(lo_v[2]),
                      int'(hi_v[0]), int'(hi_v[1]), int'(hi_v[2]));
    endfunction

    // sender: bursts of requests with random gaps, payload held while stalled
    always @(negedge clk)
    begin
        if (rst_n && !(box_valid && !box_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                box_valid <= 1'b0;
            end
            else if (pending_boxes.size() > 0)
            begin
                box <= pending_boxes.pop_front();
                box_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                box_valid <= 1'b0;
        end
        if (box_taken)
        begin
            expected_verdicts.push_back(classify_box(taken_box));
            box_taken = 1'b0;
        end
    end

    // set at the edge where a request goes in, cleared once its verdict is queued
    always @(posedge clk)
    begin
        if (rst_n && box_valid && !box_stall)
        begin
            taken_box = box;
            box_taken = 1'b1;
        end
    end

    // receiver stalls on its own pattern, switching mode every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(30, 200);
        end
        else
            stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     result_stall <= 1'b0;
            STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
            default:        result_stall <= ((stall_phase % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result with no box outstanding: visible %0b plane %0d",
                       result.visible, result.rejecting_plane);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (result.visible !== want.visible)
                begin
                    $error("visible: expected %0b, got %0b", want.visible, result.visible);
                    fail_count++;
                end
                if (result.rejecting_plane !== want.rejecting_plane)
                begin
                    $error("rejecting_plane: expected %0d, got %0d",
                           want.rejecting_plane, result.rejecting_plane);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain();
        do
            @(negedge clk);
        while (pending_boxes.size() != 0 || box_valid || box_taken ||
               expected_verdicts.size() != 0);
    endtask

    task automatic write_row(cfg_reg_t idx, logic [ROW_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        mat_rows[idx] = val;
    endtask

    // only called with the pipeline empty
    task automatic write_matrix(logic [ROW_BITS-1:0] r0, logic [ROW_BITS-1:0] r1,
                                logic [ROW_BITS-1:0] r2, logic [ROW_BITS-1:0] r3);
        drain();
        repeat (4) @(negedge clk);
        write_row(REG_MATRIX_ROW0, r0);
        write_row(REG_MATRIX_ROW1, r1);
        write_row(REG_MATRIX_ROW2, r2);
        write_row(REG_MATRIX_ROW3, r3);
        cfg_we <= 1'b0;
        // coefficient register updates in the cycle after the write
        repeat (2) @(negedge clk);
    endtask

    task automatic run_boxes(int count);
        repeat (count) pending_boxes.push_back(random_box());
        drain();
    endtask

    function automatic logic [ROW_BITS-1:0] rand_row();
        return {$urandom, $urandom};
    endfunction

    initial
    begin : timeout
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [COL_BITS-1:0] s;
        logic [COL_BITS-1:0] w;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity matrix from reset: unit cube is the frustum
        pending_boxes.push_back(mk_box(0, 0, 0, 0, 0, 0));
        pending_boxes.push_back(mk_box(-128, -128, -128, 128, 128, 128));
        pending_boxes.push_back(mk_box(-256, -256, -256, 256, 256, 256));
        pending_boxes.push_back(mk_box(-1024, 0, 0, -257, 0, 0));
        pending_boxes.push_back(mk_box(257, 0, 0, 1024, 0, 0));
        pending_boxes.push_back(mk_box(0, -1024, 0, 0, -257, 0));
        pending_boxes.push_back(mk_box(0, 257, 0, 0, 1024, 0));
        pending_boxes.push_back(mk_box(0, 0, -1024, 0, 0, -257));
        pending_boxes.push_back(mk_box(0, 0, 257, 0, 0, 1024));
        // several planes reject: lowest one wins
        pending_boxes.push_back(mk_box(-1024, 257, 0, -512, 512, 0));
        pending_boxes.push_back(mk_box(0, 257, 257, 0, 1024, 1024));
        // corners swapped
        pending_boxes.push_back(mk_box(300, 300, 300, -300, -300, -300));
        pending_boxes.push_back(mk_box(100, 100, 100, -100, -100, -100));
        // coordinate extremes
        pending_boxes.push_back(mk_box(-8388608, -8388608, -8388608,
                                       -8388608, -8388608, -8388608));
        pending_boxes.push_back(mk_box(8388607, 8388607, 8388607,
                                       8388607, 8388607, 8388607));
        pending_boxes.push_back(mk_box(-8388608, -8388608, -8388608,
                                       8388607, 8388607, 8388607));
        pending_boxes.push_back(mk_box(8388607, 8388607, 8388607,
                                       -8388608, -8388608, -8388608));
        pending_boxes.push_back(mk_box(-8388608, -8388608, -8388608, -256, -256, -256));
        pending_boxes.push_back(mk_box(256, 256, 256, 8388607, 8388607, 8388607));
        pending_boxes.push_back(mk_box(-8388608, -8388608, 257, 8388607, 8388607, 300));
        run_boxes(200);

        // zero normals: every plane reduces to the sign of w
        write_matrix('0, '0, '0, 64'hFF00_0000_0000_0000);
        pending_boxes.push_back(mk_box(0, 0, 0, 0, 0, 0));
        pending_boxes.push_back(mk_box(-8388608, -8388608, -8388608,
                                       8388607, 8388607, 8388607));
        drain();
        write_matrix('0, '0, '0, 64'h0001_0000_0000_0000);
        pending_boxes.push_back(mk_box(8388607, -8388608, 0, -8388608, 8388607, 0));
        pending_boxes.push_back(mk_box(0, 0, 0, 0, 0, 0));
        drain();

        // register extremes
        write_matrix('1, '1, '1, '1);
        run_boxes(100);
        write_matrix(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                     64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        run_boxes(100);
        write_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                     64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000);
        run_boxes(100);

        repeat (4)
        begin
            write_matrix(rand_row(), rand_row(), rand_row(), rand_row());
            run_boxes(75);
            run_boxes(75);
        end

        // scaled identity with random w
        repeat (2)
        begin
            s = COL_BITS'($urandom_range(1, 16'h7FFF));
            w = COL_BITS'($urandom);
            write_matrix({48'h0, s}, {32'h0, s, 16'h0}, {16'h0, s, 32'h0}, {w, 48'h0});
            run_boxes(75);
        end

        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/afc_pkg.sv
rtl/afc_planes.sv
rtl/afc_plane_eval.sv
rtl/aabb_frustum_cull.sv
test/aabb_frustum_cull_tb.sv
